@@ rtl/core/seven_segment_scan_controller_macros.svh @@
// Assertion macros shared by the scan controller modules.
// Stand-alone header; the including file supplies clock, reset and signals.
`ifndef SEVEN_SEGMENT_SCAN_CONTROLLER_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_CONTROLLER_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define SSC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define SSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define SSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ssc_pkg.sv @@
// Package of the seven-segment scan controller: widths, codes, fonts and types.
// No dependencies; used by the interfaces and all modules.
package ssc_pkg;

  localparam int DIGITS_DEFAULT = 5;

  localparam int SEG_W       = 8;
  localparam int SELECT_W    = 5;
  localparam int OP_W        = 3;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = 3;
  localparam int ICON_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int TICKS_W     = 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 3'd0,
    OP_PUT_CHAR    = 3'd1,
    OP_SET_ICON    = 3'd2,
    OP_CLEAR_ICON  = 3'd3,
    OP_SET_FLASH   = 3'd4,
    OP_CLEAR_FLASH = 3'd5,
    OP_FLASH_DIGIT = 3'd6,
    OP_CLEAR_ALL   = 3'd7
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_TICKS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLON_MASK  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT      = 2'd2;

  localparam logic [TICKS_W-1:0] BLINK_TICKS_RESET = 8'd250;
  localparam logic [SEG_W-1:0]   COLON_MASK_RESET  = 8'h80;
  localparam logic               INVERT_RESET      = 1'b1;

  localparam logic [SEG_W-1:0]  MINUS_PATTERN = 8'h40;
  localparam logic [SEG_W-1:0]  ALL_SEGMENTS  = 8'hff;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_COLON    = 8'h3a;
  localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7a;

  localparam logic [SEG_W-1:0] DIGIT_FONT [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  localparam logic [SEG_W-1:0] UPPER_FONT [26] = '{
    8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h40,
    8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h07,
    8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h40
  };

  localparam logic [SEG_W-1:0] LOWER_FONT [26] = '{
    8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h07,
    8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
  };

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  position;
    logic [ICON_W-1:0] icon_bits;
  } cmd_t;

  typedef struct packed {
    logic [TICKS_W-1:0] blink_ticks;
    logic [SEG_W-1:0]   colon_mask;
    logic               invert;
  } cfg_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [SEG_W-1:0] flash;
  } slot_t;

  typedef struct packed {
    logic             load;
    logic             colon;
    logic [SEG_W-1:0] pattern;
  } glyph_t;

  // Unprintable codes, space and unlisted symbols neither load nor set the colon.
  function automatic glyph_t decode_char(logic [CHAR_W-1:0] ch);
    glyph_t     g;
    logic [4:0] letter;
    g      = '0;
    letter = ch[4:0] - 5'd1;
    if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      g.load    = 1'b1;
      g.pattern = DIGIT_FONT[ch[3:0]];
    end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
      g.load    = 1'b1;
      g.pattern = LOWER_FONT[letter];
    end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
      g.load    = 1'b1;
      g.pattern = UPPER_FONT[letter];
    end else if (ch == CHAR_COLON) begin
      g.colon = 1'b1;
    end else if (ch == CHAR_MINUS) begin
      g.load    = 1'b1;
      g.pattern = MINUS_PATTERN;
    end
    return g;
  endfunction

endpackage

@@ rtl/core/ssc_cmd_if.sv @@
// Command channel of the scan controller: valid/ready handshake and command item.
// Depends on ssc_pkg.
interface ssc_cmd_if;
  logic                             valid;
  logic                             ready;
  ssc_pkg::op_t                     operation;
  logic [ssc_pkg::CHAR_W-1:0]       char_code;
  logic [ssc_pkg::POS_W-1:0]        position;
  logic [ssc_pkg::ICON_W-1:0]       icon_bits;

  modport source (output valid, operation, char_code, position, icon_bits, input ready);
  modport sink (input valid, operation, char_code, position, icon_bits, output ready);
endinterface

@@ rtl/core/ssc_drive_if.sv @@
// Drive channel of the scan controller: valid/ready handshake and one scan item.
// Depends on ssc_pkg.
interface ssc_drive_if;
  logic                         valid;
  logic                         ready;
  logic [ssc_pkg::SEG_W-1:0]    segment_drive;
  logic [ssc_pkg::SELECT_W-1:0] digit_select;

  modport source (output valid, segment_drive, digit_select, input ready);
  modport sink (input valid, segment_drive, digit_select, output ready);
endinterface

@@ rtl/core/seven_segment_scan_controller.sv @@
// Multiplexed seven-segment scan controller on ssc_pkg, the channel interfaces,
// ssc_buffers and ssc_scan. Throughput: one command item per cycle; a tick waits in
// the input register while the drive register still holds an item not yet taken.
// Each accepted item waits in the input register, then a tick loads the drive item
// or a command updates the buffers. Synchronous reset clears both buffers, scan
// index and blink state and loads blink_ticks 250, colon mask 0x80, inverted drive.
module seven_segment_scan_controller #(
  parameter int  DIGITS = ssc_pkg::DIGITS_DEFAULT,
  localparam int SLOT_W = $clog2(DIGITS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data,
  ssc_cmd_if.sink                         cmd,
  ssc_drive_if.source                     drive
);

  ssc_pkg::cfg_t     cfg;
  ssc_pkg::cmd_t     item;
  logic              item_valid;
  logic              process;
  logic              tick_fire;
  ssc_pkg::slot_t    slot;
  logic [SLOT_W-1:0] scan_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_ticks <= ssc_pkg::BLINK_TICKS_RESET;
      cfg.colon_mask  <= ssc_pkg::COLON_MASK_RESET;
      cfg.invert      <= ssc_pkg::INVERT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ssc_pkg::CFG_BLINK_TICKS: cfg.blink_ticks <= cfg_data;
        ssc_pkg::CFG_COLON_MASK:  cfg.colon_mask  <= cfg_data;
        ssc_pkg::CFG_INVERT:      cfg.invert      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A held item moves on unless it is a tick and the drive register is still full.
  assign process   = item_valid &&
                     (item.op != ssc_pkg::OP_TICK || !drive.valid || drive.ready);
  assign tick_fire = process && item.op == ssc_pkg::OP_TICK;
  assign cmd.ready = !rst && (!item_valid || process);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.ready) begin
      item_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item.op        <= cmd.operation;
      item.char_code <= cmd.char_code;
      item.position  <= cmd.position;
      item.icon_bits <= cmd.icon_bits;
    end
  end

  ssc_buffers #(
    .DIGITS (DIGITS)
  ) u_buffers (
    .clk        (clk),
    .rst        (rst),
    .cmd_fire   (process),
    .cmd        (item),
    .colon_mask (cfg.colon_mask),
    .scan_index (scan_index),
    .slot       (slot)
  );

  ssc_scan #(
    .DIGITS (DIGITS)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .tick_fire     (tick_fire),
    .cfg           (cfg),
    .slot          (slot),
    .scan_index    (scan_index),
    .out_valid     (drive.valid),
    .out_ready     (drive.ready),
    .segment_drive (drive.segment_drive),
    .digit_select  (drive.digit_select)
  );

endmodule

@@ rtl/core/ssc_buffers.sv @@
// Segment and flash buffers with the command decoder that updates them.
// Depends on ssc_pkg.
module ssc_buffers #(
  parameter int  DIGITS = ssc_pkg::DIGITS_DEFAULT,
  localparam int SLOT_W = $clog2(DIGITS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_fire,
  input  ssc_pkg::cmd_t             cmd,
  input  logic [ssc_pkg::SEG_W-1:0] colon_mask,
  input  logic [SLOT_W-1:0]         scan_index,
  output ssc_pkg::slot_t            slot
);

  localparam logic [SLOT_W-1:0] STATUS_SLOT = SLOT_W'(DIGITS - 1);

  logic [ssc_pkg::SEG_W-1:0] seg_buf   [DIGITS];
  logic [ssc_pkg::SEG_W-1:0] flash_buf [DIGITS];

  ssc_pkg::glyph_t   glyph;
  logic              in_range;
  logic [SLOT_W-1:0] pos_slot;

  always_comb begin
    glyph    = ssc_pkg::decode_char(cmd.char_code);
    in_range = {1'b0, cmd.position} < (ssc_pkg::POS_W + 1)'(DIGITS);
    pos_slot = cmd.position[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIGITS; k++) begin
        seg_buf[k]   <= '0;
        flash_buf[k] <= '0;
      end
    end else if (cmd_fire) begin
      unique case (cmd.op)
        ssc_pkg::OP_TICK: begin
        end
        ssc_pkg::OP_PUT_CHAR: begin
          if (glyph.colon) begin
            seg_buf[STATUS_SLOT] <= seg_buf[STATUS_SLOT] | colon_mask;
          end else if (glyph.load && in_range) begin
            seg_buf[pos_slot] <= glyph.pattern;
          end
        end
        ssc_pkg::OP_SET_ICON: begin
          seg_buf[STATUS_SLOT] <= seg_buf[STATUS_SLOT] | cmd.icon_bits;
        end
        ssc_pkg::OP_CLEAR_ICON: begin
          seg_buf[STATUS_SLOT] <= seg_buf[STATUS_SLOT] & ~cmd.icon_bits;
        end
        ssc_pkg::OP_SET_FLASH: begin
          flash_buf[STATUS_SLOT] <= flash_buf[STATUS_SLOT] | cmd.icon_bits;
        end
        ssc_pkg::OP_CLEAR_FLASH: begin
          flash_buf[STATUS_SLOT] <= flash_buf[STATUS_SLOT] & ~cmd.icon_bits;
        end
        ssc_pkg::OP_FLASH_DIGIT: begin
          if (in_range && pos_slot != STATUS_SLOT) begin
            flash_buf[pos_slot] <= ssc_pkg::ALL_SEGMENTS;
          end
        end
        ssc_pkg::OP_CLEAR_ALL: begin
          for (int k = 0; k < DIGITS; k++) begin
            seg_buf[k]   <= '0;
            flash_buf[k] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign slot.seg   = seg_buf[scan_index];
  assign slot.flash = flash_buf[scan_index];

endmodule

@@ rtl/core/ssc_scan.sv @@
// Scan sequencer: blink counter and phase, scan index and the drive output register.
// Depends on ssc_pkg and the assertion macro header.
`include "seven_segment_scan_controller_macros.svh"

module ssc_scan #(
  parameter int  DIGITS = ssc_pkg::DIGITS_DEFAULT,
  localparam int SLOT_W = $clog2(DIGITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick_fire,
  input  ssc_pkg::cfg_t                cfg,
  input  ssc_pkg::slot_t               slot,
  output logic [SLOT_W-1:0]            scan_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ssc_pkg::SEG_W-1:0]    segment_drive,
  output logic [ssc_pkg::SELECT_W-1:0] digit_select
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DIGITS - 1);

  logic [ssc_pkg::TICKS_W-1:0]  blink_counter;
  logic                         blink_phase;
  logic [ssc_pkg::TICKS_W-1:0]  counter_inc;
  logic                         wrap;
  logic [ssc_pkg::TICKS_W-1:0]  blink_counter_next;
  logic                         blink_phase_next;
  logic [SLOT_W-1:0]            scan_index_next;
  logic [ssc_pkg::SEG_W-1:0]    segment_drive_next;
  logic [ssc_pkg::SELECT_W-1:0] digit_select_next;

  always_comb begin
    counter_inc        = blink_counter + 1'b1;
    wrap               = counter_inc == cfg.blink_ticks;
    blink_counter_next = wrap ? '0 : counter_inc;
    blink_phase_next   = blink_phase ^ wrap;
    scan_index_next    = (scan_index == LAST_SLOT) ? '0 : scan_index + 1'b1;
    segment_drive_next = slot.seg ^ (blink_phase_next ? slot.flash : '0);
    if (cfg.invert) begin
      segment_drive_next = ~segment_drive_next;
    end
    // Slots past the width of the select field drive no common line.
    for (int b = 0; b < ssc_pkg::SELECT_W; b++) begin
      digit_select_next[b] = (b < DIGITS) && (scan_index == SLOT_W'(b));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_counter <= '0;
      blink_phase   <= 1'b0;
      scan_index    <= '0;
      out_valid     <= 1'b0;
    end else if (tick_fire) begin
      blink_counter <= blink_counter_next;
      blink_phase   <= blink_phase_next;
      scan_index    <= scan_index_next;
      out_valid     <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      segment_drive <= segment_drive_next;
      digit_select  <= digit_select_next;
    end
  end

  `SSC_ASSERT_ALWAYS(a_scan_in_range, clk, rst, scan_index <= LAST_SLOT, "scan index past last slot")
  `SSC_ASSERT_IMP(a_select_onehot, clk, rst, out_valid, $onehot0(digit_select), "select not one-hot")
  `SSC_ASSERT_NEXT(a_tick_gives_item, clk, rst, tick_fire, out_valid, "tick produced no item")
  `SSC_ASSERT_IMP(a_no_overwrite, clk, rst, tick_fire, !out_valid || out_ready, "held item overwritten")

endmodule

@@ tb/ssc_scan_checker.sv @@
// Checker of the seven-segment scan controller: watches the command, drive and
// register ports, predicts each scan item and compares it field by field.
// Depends on ssc_pkg, ssc_cmd_if and ssc_drive_if.
module ssc_scan_checker
  import ssc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  ssc_cmd_if                     cmd,
  ssc_drive_if                   drive,
  output int                     mismatches,
  output int                     pending,
  output int                     scans_checked
);

  localparam int SLOTS       = DIGITS_DEFAULT;
  localparam int STATUS_SLOT = SLOTS - 1;

  localparam logic [SEG_W-1:0] NUMERAL_GLYPHS [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };
  localparam logic [SEG_W-1:0] CAPITAL_GLYPHS [26] = '{
    8'h77, 8'h40, 8'h39, 8'h3f, 8'h79, 8'h71, 8'h40, 8'h76, 8'h06, 8'h40,
    8'h40, 8'h38, 8'h40, 8'h37, 8'h3f, 8'h73, 8'h40, 8'h50, 8'h6d, 8'h07,
    8'h3e, 8'h3e, 8'h40, 8'h76, 8'h40, 8'h40
  };
  localparam logic [SEG_W-1:0] SMALL_GLYPHS [26] = '{
    8'h77, 8'h7c, 8'h58, 8'h5e, 8'h79, 8'h71, 8'h40, 8'h40, 8'h40, 8'h40,
    8'h40, 8'h38, 8'h40, 8'h54, 8'h5c, 8'h73, 8'h67, 8'h50, 8'h40, 8'h07,
    8'h3e, 8'h3e, 8'h40, 8'h40, 8'h40, 8'h40
  };

  typedef struct packed {
    logic [SEG_W-1:0]    segments;
    logic [SELECT_W-1:0] select;
  } scan_t;

  scan_t              expected_scans [$];
  logic [SEG_W-1:0]   seg_mem [SLOTS];
  logic [SEG_W-1:0]   flash_mem [SLOTS];
  logic [POS_W-1:0]   scan_pos;
  logic [TICKS_W-1:0] blink_count;
  logic               blink_on;
  logic [TICKS_W-1:0] blink_limit;
  logic [SEG_W-1:0]   colon_bits;
  logic               active_low;
  int                 fail_count = 0;
  int                 scan_count = 0;

  assign mismatches    = fail_count;
  assign scans_checked = scan_count;

  initial pending = 0;

  function automatic void reset_model();
    for (int k = 0; k < SLOTS; k++) begin
      seg_mem[k]   = '0;
      flash_mem[k] = '0;
    end
    scan_pos    = '0;
    blink_count = '0;
    blink_on    = 1'b0;
    blink_limit = BLINK_TICKS_RESET;
    colon_bits  = COLON_MASK_RESET;
    active_low  = INVERT_RESET;
    expected_scans.delete();
  endfunction

  function automatic void apply_command(op_t op, logic [CHAR_W-1:0] ch,
                                        logic [POS_W-1:0] pos, logic [ICON_W-1:0] bits);
    scan_t            s;
    logic [SEG_W-1:0] pattern;
    logic             loads;
    int               idx;
    pattern = '0;
    loads   = 1'b1;
    case (op)
      OP_TICK: begin
        blink_count = blink_count + 8'd1;
        if (blink_count == blink_limit) begin
          blink_count = '0;
          blink_on    = ~blink_on;
        end
        idx     = int'(scan_pos);
        pattern = seg_mem[idx];
        if (blink_on) pattern = pattern ^ flash_mem[idx];
        if (active_low) pattern = ~pattern;
        s.segments = pattern;
        s.select   = SELECT_W'(1 << idx);
        expected_scans.push_back(s);
        scan_pos = (idx >= STATUS_SLOT) ? '0 : scan_pos + 3'd1;
      end
      OP_PUT_CHAR: begin
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
          pattern = NUMERAL_GLYPHS[ch - CHAR_ZERO];
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
          pattern = SMALL_GLYPHS[ch - CHAR_LOWER_A];
        end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
          pattern = CAPITAL_GLYPHS[ch - CHAR_UPPER_A];
        end else if (ch == CHAR_MINUS) begin
          pattern = MINUS_PATTERN;
        end else begin
          loads = 1'b0;
          if (ch == CHAR_COLON) seg_mem[STATUS_SLOT] = seg_mem[STATUS_SLOT] | colon_bits;
        end
        if (loads && pos < SLOTS) seg_mem[pos] = pattern;
      end
      OP_SET_ICON:    seg_mem[STATUS_SLOT] = seg_mem[STATUS_SLOT] | bits;
      OP_CLEAR_ICON:  seg_mem[STATUS_SLOT] = seg_mem[STATUS_SLOT] & ~bits;
      OP_SET_FLASH:   flash_mem[STATUS_SLOT] = flash_mem[STATUS_SLOT] | bits;
      OP_CLEAR_FLASH: flash_mem[STATUS_SLOT] = flash_mem[STATUS_SLOT] & ~bits;
      OP_FLASH_DIGIT: begin
        if (pos < SLOTS && pos != STATUS_SLOT) flash_mem[pos] = ALL_SEGMENTS;
      end
      default: begin
        for (int k = 0; k < SLOTS; k++) begin
          seg_mem[k]   = '0;
          flash_mem[k] = '0;
        end
      end
    endcase
  endfunction

  function automatic void note_failure(string what, logic [SEG_W-1:0] want,
                                       logic [SEG_W-1:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("checker: %s expected %02h got %02h (scan item %0d)",
               what, want, got, scan_count);
    end
  endfunction

  function automatic void check_scan();
    scan_t want;
    if (expected_scans.size() == 0) begin
      note_failure("drive item with nothing expected, segment_drive", '0,
                   drive.segment_drive);
    end else begin
      want = expected_scans.pop_front();
      if (drive.segment_drive !== want.segments)
        note_failure("segment_drive", want.segments, drive.segment_drive);
      if (drive.digit_select !== want.select)
        note_failure("digit_select", SEG_W'(want.select), SEG_W'(drive.digit_select));
    end
    scan_count++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
    end else begin
      if (drive.valid && drive.ready) check_scan();
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BLINK_TICKS: blink_limit = cfg_data[TICKS_W-1:0];
          CFG_COLON_MASK:  colon_bits  = cfg_data[SEG_W-1:0];
          CFG_INVERT:      active_low  = cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready)
        apply_command(cmd.operation, cmd.char_code, cmd.position, cmd.icon_bits);
    end
    pending <= expected_scans.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the scan controller testbench: clock, reset, command and register stimulus,
// receiver stalls and the verdict. Depends on ssc_pkg, the channel interfaces,
// ssc_scan_checker and seven_segment_scan_controller.
module testbench;
  import ssc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  ssc_cmd_if   cmd_ch ();
  ssc_drive_if drive_ch ();

  int mismatches;
  int pending;
  int scans_checked;
  int cycle_count = 0;
  int items_sent  = 0;
  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_pending = 1'b0;

  logic [TICKS_W-1:0] phase_ticks [PHASES] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd5, 8'd3, 8'd7};
  logic [SEG_W-1:0]   phase_colon [PHASES] = '{8'h00, 8'hff, 8'h01, 8'h5a, 8'h80, 8'h24, 8'h00};
  logic               phase_inv   [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  int                 phase_items [PHASES] = '{140, 600, 140, 140, 140, 140, 140};

  seven_segment_scan_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .drive     (drive_ch)
  );

  ssc_scan_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd_ch),
    .drive         (drive_ch),
    .mismatches    (mismatches),
    .pending       (pending),
    .scans_checked (scans_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, runs of steady acceptance, and one long hold-off.
  initial begin
    drive_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        drive_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        drive_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        drive_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic cmd_t make_cmd(op_t op, logic [CHAR_W-1:0] ch,
                                    logic [POS_W-1:0] pos, logic [ICON_W-1:0] bits);
    cmd_t c;
    c.op        = op;
    c.char_code = ch;
    c.position  = pos;
    c.icon_bits = bits;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    c = make_cmd(OP_TICK, 8'($urandom), 3'($urandom_range(0, 4)), 8'($urandom));
    if ($urandom_range(0, 7) == 0) c.position = 3'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.op = OP_TICK;
    end else if (pick < 72) begin
      c.op = OP_PUT_CHAR;
      case ($urandom_range(0, 5))
        0: c.char_code = CHAR_ZERO + 8'($urandom_range(0, 9));
        1: c.char_code = CHAR_UPPER_A + 8'($urandom_range(0, 25));
        2: c.char_code = CHAR_LOWER_A + 8'($urandom_range(0, 25));
        3: c.char_code = $urandom_range(0, 1) ? CHAR_COLON : CHAR_MINUS;
        default: ;
      endcase
    end else if (pick < 78) begin
      c.op = OP_SET_ICON;
    end else if (pick < 84) begin
      c.op = OP_CLEAR_ICON;
    end else if (pick < 89) begin
      c.op = OP_SET_FLASH;
    end else if (pick < 93) begin
      c.op = OP_CLEAR_FLASH;
    end else if (pick < 98) begin
      c.op = OP_FLASH_DIGIT;
    end else begin
      c.op = OP_CLEAR_ALL;
    end
    return c;
  endfunction

  task automatic send_item(input cmd_t c);
    if (send_idle && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= c.op;
    cmd_ch.char_code <= c.char_code;
    cmd_ch.position  <= c.position;
    cmd_ch.icon_bits <= c.icon_bits;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  initial begin
    cmd_t directed [$];
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.operation <= OP_TICK;
    cmd_ch.char_code <= '0;
    cmd_ch.position  <= '0;
    cmd_ch.icon_bits <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Extremes of every field, every operation and the corner cases of put char.
    directed = '{
      make_cmd(OP_TICK, 8'h00, 3'd0, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_ZERO, 3'd0, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_LOWER_Z, 3'd1, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_UPPER_A, 3'd2, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_MINUS, 3'd3, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_UPPER_Z, 3'd4, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_COLON, 3'd7, 8'hff),
      make_cmd(OP_PUT_CHAR, 8'h20, 3'd0, 8'h00),
      make_cmd(OP_PUT_CHAR, 8'h23, 3'd1, 8'h00),
      make_cmd(OP_PUT_CHAR, 8'h1f, 3'd2, 8'h00),
      make_cmd(OP_PUT_CHAR, 8'h7f, 3'd3, 8'h00),
      make_cmd(OP_PUT_CHAR, 8'hff, 3'd0, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_NINE, 3'd5, 8'h00),
      make_cmd(OP_PUT_CHAR, CHAR_LOWER_A, 3'd7, 8'h00),
      make_cmd(OP_SET_ICON, 8'h00, 3'd0, 8'hff),
      make_cmd(OP_CLEAR_ICON, 8'h00, 3'd0, 8'h0f),
      make_cmd(OP_SET_FLASH, 8'h00, 3'd0, 8'haa),
      make_cmd(OP_CLEAR_FLASH, 8'h00, 3'd0, 8'h0a),
      make_cmd(OP_FLASH_DIGIT, 8'h00, 3'd0, 8'h00),
      make_cmd(OP_FLASH_DIGIT, 8'h00, 3'd4, 8'h00),
      make_cmd(OP_FLASH_DIGIT, 8'h00, 3'd6, 8'h00),
      make_cmd(OP_TICK, 8'h00, 3'd0, 8'h00),
      make_cmd(OP_TICK, 8'h00, 3'd0, 8'h00),
      make_cmd(OP_TICK, 8'h00, 3'd0, 8'h00),
      make_cmd(OP_TICK, 8'h00, 3'd0, 8'h00),
      make_cmd(OP_TICK, 8'h00, 3'd0, 8'h00),
      make_cmd(OP_CLEAR_ALL, 8'hff, 3'd7, 8'hff),
      make_cmd(OP_TICK, 8'hff, 3'd7, 8'hff)
    };
    foreach (directed[k]) send_item(directed[k]);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(CFG_BLINK_TICKS, (p == PHASES - 1) ? 8'($urandom_range(1, 12)) : phase_ticks[p]);
      write_reg(CFG_COLON_MASK, (p == PHASES - 2) ? 8'($urandom) : phase_colon[p]);
      write_reg(CFG_INVERT, CFG_DATA_W'(phase_inv[p]));
      cfg_wr_en <= 1'b0;
      send_idle = (p != 3 && p != PHASES - 1);
      recv_idle = send_idle;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 2 && n == 30) hold_pending = 1'b1;
        send_item(random_cmd());
      end
    end

    wait_drained();
    $display("summary: %0d command items sent over %0d register settings, %0d scan items checked",
             items_sent, PHASES + 1, scans_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
